>>> rtl/utbs_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the upper triangular back substitution block. No dependencies.
package utbs_pkg;

  localparam int unsigned MaxUnknowns = 16;
  localparam int unsigned IdxW        = $clog2(MaxUnknowns);
  localparam int unsigned CntW        = IdxW + 1;
  localparam int unsigned CoefAW      = 2 * IdxW;
  localparam int unsigned DataW       = 32;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned QuotW       = DataW + FracBits;
  localparam int unsigned StepW       = $clog2(QuotW + 1);

  localparam logic [1:0] ActLoadCoef = 2'd0;
  localparam logic [1:0] ActLoadFree = 2'd1;
  localparam logic [1:0] ActSolve    = 2'd2;

  localparam logic [CntW-1:0] UnknownCountReset = CntW'(MaxUnknowns);

  typedef struct packed {
    logic            coef_we;
    logic            free_we;
    logic            rd_term;
    logic            cap_row;
    logic            mul;
    logic            acc;
    logic            div_load;
    logic            div_step;
    logic            wr_x;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } utbs_cmd_t;

  typedef struct packed {
    logic pivot_zero;
  } utbs_sts_t;

endpackage

>>> rtl/utbs_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module utbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/utbs_ctrl.sv
// Sequencing state machine: loads, row/term walk, divider steps, result handoff.
// Depends on utbs_pkg.
module utbs_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [utbs_pkg::CntW-1:0]       n_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      action_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [utbs_pkg::IdxW-1:0]       unknown_index_o,
  output logic                            last_result_o,
  input  utbs_pkg::utbs_sts_t             sts_i,
  output utbs_pkg::utbs_cmd_t             cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROW   = 4'd1;
  localparam logic [3:0] S_ROWW  = 4'd2;
  localparam logic [3:0] S_TERM  = 4'd3;
  localparam logic [3:0] S_TERMW = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_DIV0  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_WR    = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]                  state_q, state_d;
  logic [utbs_pkg::IdxW-1:0]   row_q, row_d;
  logic [utbs_pkg::CntW-1:0]   col_q, col_d;
  logic [utbs_pkg::StepW-1:0]  step_q, step_d;
  logic                        in_acc;
  logic [utbs_pkg::CntW-1:0]   col_first, col_next;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign col_first  = {1'b0, row_q} + utbs_pkg::CntW'(1);
  assign col_next   = col_q + utbs_pkg::CntW'(1);

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    step_d       = step_q;
    cmd_o        = '0;
    cmd_o.row    = row_q;
    cmd_o.col    = col_q[utbs_pkg::IdxW-1:0];
    out_valid_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (action_i)
            utbs_pkg::ActLoadCoef: cmd_o.coef_we = 1'b1;
            utbs_pkg::ActLoadFree: cmd_o.free_we = 1'b1;
            utbs_pkg::ActSolve: begin
              row_d   = utbs_pkg::IdxW'(n_i - utbs_pkg::CntW'(1));
              state_d = S_ROW;
            end
            default: ;
          endcase
        end
      end
      S_ROW:  state_d = S_ROWW;
      S_ROWW: begin
        cmd_o.cap_row = 1'b1;
        col_d         = col_first;
        state_d       = (col_first < n_i) ? S_TERM : S_DIV0;
      end
      S_TERM: begin
        cmd_o.rd_term = 1'b1;
        state_d       = S_TERMW;
      end
      S_TERMW: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        col_d     = col_next;
        state_d   = (col_next < n_i) ? S_TERM : S_DIV0;
      end
      S_DIV0: begin
        step_d = '0;
        if (sts_i.pivot_zero) begin
          state_d = S_WR;
        end else begin
          cmd_o.div_load = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + utbs_pkg::StepW'(1);
        if (step_q == utbs_pkg::StepW'(utbs_pkg::QuotW - 1)) begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        cmd_o.wr_x = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (row_q == '0) begin
            state_d = S_IDLE;
          end else begin
            row_d   = row_q - utbs_pkg::IdxW'(1);
            state_d = S_ROW;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign unknown_index_o = row_q;
  assign last_result_o   = (row_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      step_q  <= step_d;
    end
  end

endmodule

>>> rtl/utbs_dp.sv
// Datapath: coefficient, free term and solution RAMs, multiply-accumulate,
// bit-serial divider and result register. Depends on utbs_pkg, utbs_ram.
module utbs_dp (
  input  logic                              clk_i,
  input  utbs_pkg::utbs_cmd_t               cmd_i,
  input  logic [utbs_pkg::IdxW-1:0]         row_index_i,
  input  logic [utbs_pkg::IdxW-1:0]         column_index_i,
  input  logic signed [utbs_pkg::DataW-1:0] load_value_i,
  output logic signed [utbs_pkg::DataW-1:0] solution_value_o,
  output logic                              zero_pivot_o,
  output utbs_pkg::utbs_sts_t               sts_o
);

  localparam int unsigned DW = utbs_pkg::DataW;
  localparam int unsigned QW = utbs_pkg::QuotW;
  localparam logic signed [2*DW-1:0] MaxP64 = (2*DW)'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [2*DW-1:0] MinP64 = -MaxP64 - (2*DW)'(1);
  localparam logic signed [DW:0]     MaxP33 = (DW+1)'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [DW:0]     MinP33 = -MaxP33 - (DW+1)'(1);
  localparam logic [QW-1:0]          MaxQ   = QW'({1'b0, {(DW-1){1'b1}}});
  localparam logic [DW-1:0]          MaxX   = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]          MinX   = {1'b1, {(DW-1){1'b0}}};

  logic [utbs_pkg::CoefAW-1:0] coef_raddr;
  logic [utbs_pkg::IdxW-1:0]   sol_raddr;
  logic [DW-1:0]               coef_rdata, free_rdata, sol_rdata;

  logic signed [DW-1:0]    acc_q, piv_q;
  logic signed [2*DW-1:0]  prod_q, prod_sh;
  logic signed [DW-1:0]    prod_sat;
  logic signed [DW:0]      diff;
  logic [QW-1:0]           dq_q;
  logic [DW:0]             rem_q, rem_sh;
  logic [DW-1:0]           dvs_q, acc_mag;
  logic                    neg_q, ge;
  logic [DW-1:0]           x_d;
  logic [DW-1:0]           value_q;
  logic                    zero_q;

  assign coef_raddr = cmd_i.rd_term ? {cmd_i.row, cmd_i.col} : {cmd_i.row, cmd_i.row};
  assign sol_raddr  = cmd_i.col;

  utbs_ram #(.WIDTH(DW), .DEPTH(utbs_pkg::MaxUnknowns * utbs_pkg::MaxUnknowns)) u_coef (
    .clk_i   (clk_i),
    .we_i    (cmd_i.coef_we),
    .waddr_i ({row_index_i, column_index_i}),
    .wdata_i (load_value_i),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  utbs_ram #(.WIDTH(DW), .DEPTH(utbs_pkg::MaxUnknowns)) u_free (
    .clk_i   (clk_i),
    .we_i    (cmd_i.free_we),
    .waddr_i (row_index_i),
    .wdata_i (load_value_i),
    .raddr_i (cmd_i.row),
    .rdata_o (free_rdata)
  );

  utbs_ram #(.WIDTH(DW), .DEPTH(utbs_pkg::MaxUnknowns)) u_sol (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_x),
    .waddr_i (cmd_i.row),
    .wdata_i (x_d),
    .raddr_i (sol_raddr),
    .rdata_o (sol_rdata)
  );

  // floor shift of the product, then saturating subtract
  assign prod_sh  = prod_q >>> utbs_pkg::FracBits;
  assign prod_sat = (prod_sh > MaxP64) ? MaxX :
                    (prod_sh < MinP64) ? MinX : prod_sh[DW-1:0];
  assign diff     = {acc_q[DW-1], acc_q} - {prod_sat[DW-1], prod_sat};

  assign acc_mag = acc_q[DW-1] ? (~acc_q + DW'(1)) : acc_q;
  assign rem_sh  = {rem_q[DW-1:0], dq_q[QW-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    if (piv_q == '0) begin
      x_d = '0;
    end else if (neg_q) begin
      x_d = (dq_q > MaxQ + QW'(1)) ? MinX : (~dq_q[DW-1:0] + DW'(1));
    end else begin
      x_d = (dq_q > MaxQ) ? MaxX : dq_q[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_row) begin
      acc_q <= free_rdata;
      piv_q <= coef_rdata;
    end
    if (cmd_i.mul) begin
      prod_q <= $signed(coef_rdata) * $signed(sol_rdata);
    end
    if (cmd_i.acc) begin
      acc_q <= (diff > MaxP33) ? MaxX : (diff < MinP33) ? MinX : diff[DW-1:0];
    end
    if (cmd_i.div_load) begin
      dq_q  <= {acc_mag, {utbs_pkg::FracBits{1'b0}}};
      rem_q <= '0;
      dvs_q <= piv_q[DW-1] ? (~piv_q + DW'(1)) : piv_q;
      neg_q <= acc_q[DW-1] ^ piv_q[DW-1];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      dq_q  <= {dq_q[QW-2:0], ge};
    end
    if (cmd_i.wr_x) begin
      value_q <= x_d;
      zero_q  <= (piv_q == '0);
    end
  end

  assign solution_value_o = value_q;
  assign zero_pivot_o     = zero_q;
  assign sts_o.pivot_zero = (piv_q == '0);

endmodule

>>> rtl/upper_triangular_back_substitution.sv
// Top level of the upper triangular back substitution block: APB register,
// controller and datapath. Depends on utbs_pkg, utbs_ctrl, utbs_dp.
//
// Usage: input transactions (valid/ready) carry action, row_index,
// column_index and load_value. A load coefficient or load free term
// transaction writes one store entry and gives no result.
// A solve transaction yields one result transaction per unknown, from
// unknown_count-1 down to 0; last_result marks unknown 0.
// Per unknown i of n: row fetch, a read, multiply and accumulate per
// term j>i through the single multiplier, a pivot check, the
// one-bit-per-cycle divider (skipped on a zero pivot), write-back,
// then the result is held until taken. in_ready is low for the
// whole solve. The receiver may stall freely; the walk pauses on the
// pending result.
// unknown_count sits at APB byte address 0 (values clamp to 1..16).
// Reset sets unknown_count to 16 and returns the controller to idle;
// the stores keep no reset value and must be loaded before a solve.
module upper_triangular_back_substitution (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic [utbs_pkg::IdxW-1:0]         row_index_i,
  input  logic [utbs_pkg::IdxW-1:0]         column_index_i,
  input  logic signed [utbs_pkg::DataW-1:0] load_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [utbs_pkg::IdxW-1:0]         unknown_index_o,
  output logic signed [utbs_pkg::DataW-1:0] solution_value_o,
  output logic                              zero_pivot_o,
  output logic                              last_result_o
);

  logic [4:0]                 count_q;
  logic [utbs_pkg::CntW-1:0]  n_eff;
  utbs_pkg::utbs_cmd_t        cmd;
  utbs_pkg::utbs_sts_t        sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 5'(utbs_pkg::UnknownCountReset);
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      count_q <= pwdata[4:0];
    end
  end

  always_comb begin
    if (count_q == '0) begin
      n_eff = utbs_pkg::CntW'(1);
    end else if (count_q > 5'(utbs_pkg::MaxUnknowns)) begin
      n_eff = utbs_pkg::CntW'(utbs_pkg::MaxUnknowns);
    end else begin
      n_eff = utbs_pkg::CntW'(count_q);
    end
  end

  utbs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .n_i             (n_eff),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .unknown_index_o (unknown_index_o),
    .last_result_o   (last_result_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  utbs_dp u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .row_index_i      (row_index_i),
    .column_index_i   (column_index_i),
    .load_value_i     (load_value_i),
    .solution_value_o (solution_value_o),
    .zero_pivot_o     (zero_pivot_o),
    .sts_o            (sts)
  );

endmodule

>>> rtl/utbs_checker.sv
// Port-level assertions for the back substitution top level, and its bind.
// Depends on utbs_pkg and upper_triangular_back_substitution.
module utbs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [utbs_pkg::IdxW-1:0]         unknown_index_o,
  input logic signed [utbs_pkg::DataW-1:0] solution_value_o,
  input logic                              zero_pivot_o,
  input logic                              last_result_o
);

  a_busy_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready during a solve");

  a_last_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_result_o) |-> (unknown_index_o == '0))
    else $error("last result not on unknown 0");

  a_zero_pivot_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_pivot_o) |-> (solution_value_o == '0))
    else $error("zero pivot with nonzero value");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_result_o) |=> (in_ready_o && !out_valid_o))
    else $error("not idle after last result");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(solution_value_o)
      && $stable(unknown_index_o))) else $error("stalled result changed");

endmodule

bind upper_triangular_back_substitution utbs_checker u_utbs_checker (.*);
